### src/adtg_pkg.sv
// Package for the additive drum tone generator: field widths, register indexes,
// reset values and the quarter-wave sine table.
// Has no dependencies; every other file refers to it by scoped names.
package adtg_pkg;

	localparam int PHASE_STEPS = 8000;
	localparam int QUARTER     = PHASE_STEPS / 4;
	localparam int HALF        = PHASE_STEPS / 2;

	localparam int BASE_W     = 12;
	localparam int CNT_W      = 7;
	localparam int AMP_W      = 15;
	localparam int LEN_W      = 16;
	localparam int SAMPLE_W   = 16;
	localparam int PHASE_W    = 13;
	localparam int SINE_W     = 15;
	localparam int QIDX_W     = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PHASE_W-1:0] PHASE_MOD    = PHASE_W'(PHASE_STEPS);
	localparam logic [PHASE_W-1:0] PHASE_HALF   = PHASE_W'(HALF);
	localparam logic [PHASE_W-1:0] PHASE_QUART  = PHASE_W'(QUARTER);

	localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARTIALS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_AMP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_LEN  = 2'd3;

	localparam logic [BASE_W-1:0] BASE_FREQ_RST = 12'd100;
	localparam logic [CNT_W-1:0]  PARTIALS_RST  = 7'd50;
	localparam logic [AMP_W-1:0]  PEAK_AMP_RST  = 15'd16000;
	localparam logic [LEN_W-1:0]  TONE_LEN_RST  = 16'd1000;

	localparam int DIV_NUM_W    = 2 * LEN_W;
	localparam int DIV_STEPS    = 2;
	localparam int DIV_A_CYCLES = DIV_NUM_W / DIV_STEPS;
	localparam int DIV_B_CYCLES = LEN_W / DIV_STEPS;
	localparam int DIV_CNT_W    = $clog2(DIV_A_CYCLES + 1);

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [SINE_W-1:0] qtab_t [QUARTER+1];

	// Q30 Taylor series of the sine, rounded to Q0.15, over the first quarter.
	function automatic qtab_t build_qtab();
		qtab_t             tab;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint unsigned   r;
		longint            acc;
		int                k;
		int                n;
		for (k = 0; k <= QUARTER; k++) begin
			x    = (64'(k) * HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			r = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
			if (r > 64'd32767) begin
				r = 64'd32767;
			end
			tab[k] = r[SINE_W-1:0];
		end
		return tab;
	endfunction

	localparam qtab_t SINE_QTAB = build_qtab();

endpackage

### src/additive_drum_tone_generator_unit.sv
// Top level of the additive drum tone generator: configuration registers,
// envelope divider and the partial pass over the phase memory.
// Depends on adtg_pkg for widths, register indexes and the sine table.
//
// Usage: each transaction on the input channel (in_valid/in_ready, field restart)
// asks for the next sample of a linearly decaying tone. The result leaves on the
// output channel (out_valid/out_ready, fields sample and last); last marks the
// final sample of the tone, after which the next tone starts at sample zero.
// Registers must be written by the user through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce it. From an accepted
// input, the block forms the envelope product, divides it by the tone length and
// then by the partial count (two quotient bits a cycle), makes one pass over the
// phase memory, one entry a cycle, through a three-stage pipeline, waits for the
// pipeline to drain, then loads the output register once that register is free.
// One input is worked on at a time, so a new input is taken only after the
// previous result has been loaded into the output register.
// The finished result sits in an output register, so the next input is taken
// while it waits; if the receiver stalls, a following result waits in the block
// until the register is free. Reset loads the register defaults, returns the
// tone to sample zero and clears every phase through per-entry valid bits,
// with no clearing pass; restart and the end of a tone clear them the same way.
module additive_drum_tone_generator_unit #(
	parameter int MAX_PARTIALS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [adtg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adtg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [adtg_pkg::SAMPLE_W-1:0] sample,
	output logic                                 last
);

	localparam int PTR_W = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
	localparam int CE_W  = ($clog2(MAX_PARTIALS + 1) > adtg_pkg::CNT_W) ?
		$clog2(MAX_PARTIALS + 1) : adtg_pkg::CNT_W;
	localparam logic [CE_W-1:0]  MAX_CNT  = CE_W'(MAX_PARTIALS);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_PARTIALS - 1);
	localparam int PROD_W = 2 * adtg_pkg::AMP_W;
	localparam int NUM_W  = adtg_pkg::AMP_W + adtg_pkg::LEN_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIVA = 3'd2;
	localparam logic [2:0] ST_DIVB = 3'd3;
	localparam logic [2:0] ST_PASS = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [adtg_pkg::BASE_W-1:0]    base_q;
	logic [adtg_pkg::CNT_W-1:0]     partials_q;
	logic [adtg_pkg::AMP_W-1:0]     peak_q;
	logic [adtg_pkg::LEN_W-1:0]     tone_len_q;

	logic [2:0]                     state_q;
	logic [adtg_pkg::LEN_W-1:0]     idx_q;
	logic                           last_cur_q;
	logic [MAX_PARTIALS-1:0]        pv_q;
	logic [PTR_W-1:0]               rd_ptr_q;
	logic                           issuing_q;
	logic [adtg_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [adtg_pkg::LEN_W:0]       rem_q;
	logic [adtg_pkg::DIV_NUM_W-1:0] num_q;
	logic [adtg_pkg::LEN_W-1:0]     divisor_q;
	logic [adtg_pkg::AMP_W-1:0]     env_q;
	logic [adtg_pkg::SAMPLE_W-1:0]  sum_q;
	logic                           out_valid_q;
	logic [adtg_pkg::SAMPLE_W-1:0]  sample_q;
	logic                           last_q;

	logic [adtg_pkg::PHASE_W-1:0]   phase_mem [MAX_PARTIALS];

	logic                           vld_s1;
	logic [PTR_W-1:0]               j_s1;
	logic                           pv_s1;
	logic [adtg_pkg::PHASE_W-1:0]   phase_rd_s1;
	logic                           vld_s2;
	logic                           neg_s2;
	logic                           act_s2;
	logic [adtg_pkg::SINE_W-1:0]    rom_s2;
	logic                           vld_s3;
	logic                           neg_s3;
	logic                           act_s3;
	logic [PROD_W-1:0]              prod_s3;

	logic                           in_acc;
	logic                           issue;
	logic                           clear_tone;
	logic [adtg_pkg::LEN_W-1:0]     len_eff;
	logic [CE_W-1:0]                cnt_raw;
	logic [CE_W-1:0]                cnt_eff;
	logic [adtg_pkg::LEN_W-1:0]     idx_eff;
	logic [adtg_pkg::LEN_W-1:0]     env_diff;
	logic [NUM_W-1:0]               num_prod;
	logic [adtg_pkg::LEN_W:0]       rem_nx;
	logic [adtg_pkg::DIV_NUM_W-1:0] num_nx;
	logic [adtg_pkg::LEN_W:0]       trial;
	logic [adtg_pkg::PHASE_W-1:0]   phase_cur;
	logic [adtg_pkg::PHASE_W-1:0]   step_raw;
	logic [adtg_pkg::PHASE_W-1:0]   step;
	logic [adtg_pkg::PHASE_W:0]     phase_sum;
	logic [adtg_pkg::PHASE_W-1:0]   phase_nx;
	logic                           neg_s1;
	logic [adtg_pkg::PHASE_W-1:0]   half_ph;
	logic [adtg_pkg::QIDX_W-1:0]    qidx;
	logic [adtg_pkg::SAMPLE_W-1:0]  term_mag;
	logic [adtg_pkg::SAMPLE_W-1:0]  term;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign issue     = (state_q == ST_PASS) && issuing_q;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

	always_comb begin
		len_eff = (tone_len_q == '0) ? adtg_pkg::LEN_W'(1) : tone_len_q;
		cnt_raw = CE_W'(partials_q);
		if (cnt_raw == '0) begin
			cnt_eff = CE_W'(1);
		end else if (cnt_raw > MAX_CNT) begin
			cnt_eff = MAX_CNT;
		end else begin
			cnt_eff = cnt_raw;
		end
		clear_tone = restart || (idx_q >= len_eff);
		idx_eff    = clear_tone ? '0 : idx_q;
		env_diff   = len_eff - idx_q;
		num_prod   = NUM_W'(peak_q) * NUM_W'(env_diff);
	end

	always_comb begin
		rem_nx = rem_q;
		num_nx = num_q;
		trial  = '0;
		for (int i = 0; i < adtg_pkg::DIV_STEPS; i++) begin
			trial  = {rem_nx[adtg_pkg::LEN_W-1:0], num_nx[adtg_pkg::DIV_NUM_W-1]};
			num_nx = {num_nx[adtg_pkg::DIV_NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				trial     = trial - {1'b0, divisor_q};
				num_nx[0] = 1'b1;
			end
			rem_nx = trial;
		end
	end

	always_comb begin
		phase_cur = pv_s1 ? phase_rd_s1 : '0;
		step_raw  = adtg_pkg::PHASE_W'(base_q) + adtg_pkg::PHASE_W'(j_s1);
		step      = (step_raw >= adtg_pkg::PHASE_MOD) ? step_raw - adtg_pkg::PHASE_MOD
			: step_raw;
		phase_sum = {1'b0, phase_cur} + {1'b0, step};
		phase_nx  = (phase_sum >= {1'b0, adtg_pkg::PHASE_MOD}) ?
			adtg_pkg::PHASE_W'(phase_sum - {1'b0, adtg_pkg::PHASE_MOD}) :
			phase_sum[adtg_pkg::PHASE_W-1:0];
		neg_s1    = (phase_cur >= adtg_pkg::PHASE_HALF);
		half_ph   = neg_s1 ? phase_cur - adtg_pkg::PHASE_HALF : phase_cur;
		qidx      = (half_ph <= adtg_pkg::PHASE_QUART) ? adtg_pkg::QIDX_W'(half_ph)
			: adtg_pkg::QIDX_W'(adtg_pkg::PHASE_HALF - half_ph);
		term_mag  = adtg_pkg::SAMPLE_W'(prod_s3[PROD_W-1:adtg_pkg::SINE_W]);
		term      = neg_s3 ? (adtg_pkg::SAMPLE_W'(0) - term_mag) : term_mag;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			phase_rd_s1 <= phase_mem[rd_ptr_q];
		end
		if (vld_s1) begin
			phase_mem[j_s1] <= phase_nx;
		end
	end

	always_ff @(posedge clk) begin
		j_s1    <= rd_ptr_q;
		pv_s1   <= pv_q[rd_ptr_q];
		rom_s2  <= adtg_pkg::SINE_QTAB[qidx];
		neg_s2  <= neg_s1;
		act_s2  <= (CE_W'(j_s1) < cnt_eff);
		prod_s3 <= PROD_W'(env_q) * PROD_W'(rom_s2);
		neg_s3  <= neg_s2;
		act_s3  <= act_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= adtg_pkg::BASE_FREQ_RST;
			partials_q <= adtg_pkg::PARTIALS_RST;
			peak_q     <= adtg_pkg::PEAK_AMP_RST;
			tone_len_q <= adtg_pkg::TONE_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adtg_pkg::REG_BASE_FREQ: base_q     <= cfg_data[adtg_pkg::BASE_W-1:0];
				adtg_pkg::REG_PARTIALS:  partials_q <= cfg_data[adtg_pkg::CNT_W-1:0];
				adtg_pkg::REG_PEAK_AMP:  peak_q     <= cfg_data[adtg_pkg::AMP_W-1:0];
				adtg_pkg::REG_TONE_LEN:  tone_len_q <= cfg_data[adtg_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			last_cur_q  <= 1'b0;
			pv_q        <= '0;
			rd_ptr_q    <= '0;
			issuing_q   <= 1'b0;
			div_cnt_q   <= '0;
			rem_q       <= '0;
			num_q       <= '0;
			divisor_q   <= '0;
			env_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
			last_q      <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (vld_s1) begin
				pv_q[j_s1] <= 1'b1;
			end
			if (vld_s3 && act_s3) begin
				sum_q <= sum_q + term;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						idx_q      <= idx_eff;
						last_cur_q <= (idx_eff == len_eff - adtg_pkg::LEN_W'(1));
						if (clear_tone) begin
							pv_q <= '0;
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					num_q     <= adtg_pkg::DIV_NUM_W'(num_prod);
					rem_q     <= '0;
					divisor_q <= len_eff;
					div_cnt_q <= adtg_pkg::DIV_CNT_W'(adtg_pkg::DIV_A_CYCLES);
					state_q   <= ST_DIVA;
				end
				ST_DIVA: begin
					div_cnt_q <= div_cnt_q - adtg_pkg::DIV_CNT_W'(1);
					rem_q     <= rem_nx;
					num_q     <= num_nx;
					if (div_cnt_q == adtg_pkg::DIV_CNT_W'(1)) begin
						num_q     <= {num_nx[adtg_pkg::LEN_W-1:0], adtg_pkg::LEN_W'(0)};
						rem_q     <= '0;
						divisor_q <= adtg_pkg::LEN_W'(cnt_eff);
						div_cnt_q <= adtg_pkg::DIV_CNT_W'(adtg_pkg::DIV_B_CYCLES);
						state_q   <= ST_DIVB;
					end
				end
				ST_DIVB: begin
					div_cnt_q <= div_cnt_q - adtg_pkg::DIV_CNT_W'(1);
					rem_q     <= rem_nx;
					num_q     <= num_nx;
					if (div_cnt_q == adtg_pkg::DIV_CNT_W'(1)) begin
						env_q     <= num_nx[adtg_pkg::AMP_W-1:0];
						sum_q     <= '0;
						rd_ptr_q  <= '0;
						issuing_q <= 1'b1;
						state_q   <= ST_PASS;
					end
				end
				ST_PASS: begin
					if (issuing_q) begin
						if (rd_ptr_q == LAST_PTR) begin
							issuing_q <= 1'b0;
						end else begin
							rd_ptr_q <= rd_ptr_q + PTR_W'(1);
						end
					end else if (!vld_s1 && !vld_s2 && !vld_s3) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						sample_q    <= sum_q;
						last_q      <= last_cur_q;
						if (last_cur_q) begin
							idx_q <= '0;
							pv_q  <= '0;
						end else begin
							idx_q <= idx_q + adtg_pkg::LEN_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/adtg_checker.sv
// Port checker for the additive drum tone generator, bound to the top level.
// Depends on adtg_pkg for the sample width.
module adtg_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [adtg_pkg::SAMPLE_W-1:0] sample,
	input logic                                 last
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last))
		else $error("result changed or vanished while stalled");

	// The block works on one input transaction at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input taken again right after a transaction");

	// No result appears without an input transaction behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a pending input transaction");

	// At most the waiting result is outstanding when a new input is taken.
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> pend_q <= 2'd1)
		else $error("too many transactions outstanding");

endmodule

bind additive_drum_tone_generator_unit adtg_checker u_adtg_checker (.*);
